/* rtl/rthb_pkg.sv */
// shared types, constants and divider step for the rgb to hsv converter
package rthb_pkg;

	localparam int unsigned DIV_STAGES = 4;

	localparam logic [7:0] HUE_SECTOR = 8'd43;
	localparam logic [7:0] HUE_GREEN  = 8'd86;
	localparam logic [7:0] HUE_BLUE   = 8'd172;

	typedef logic [1:0] sector_t;
	localparam sector_t SEC_RED   = 2'd0;
	localparam sector_t SEC_GREEN = 2'd1;
	localparam sector_t SEC_BLUE  = 2'd2;

	// pixel facts that ride alongside the dividers
	typedef struct packed {
		sector_t     sector;
		logic        neg;
		logic [7:0]  maxv;
		logic [7:0]  delta;
	} side_t;

	// partial remainder on top, numerator bits shifting out / quotient bits shifting in
	typedef struct packed {
		logic [7:0] rem;
		logic [7:0] low;
	} div_t;

	typedef struct packed {
		side_t side;
		div_t  sat;
		div_t  hue;
	} item_t;

	// one restoring division step, divisor of eight bits, quotient below 256
	function automatic div_t div_step(input div_t w, input logic [7:0] d);
		logic [8:0] t;
		logic [8:0] diff;
		logic       ge;
		div_t       r;
		t    = {w.rem, w.low[7]};
		diff = t - {1'b0, d};
		ge   = (t >= {1'b0, d});
		r.rem = ge ? diff[7:0] : t[7:0];
		r.low = {w.low[6:0], ge};
		return r;
	endfunction

endpackage

/* rtl/rthb_front.sv */
// max, min and sector pick, then divider numerators and initial remainders
module rthb_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_valid,
	input  logic [7:0]           red,
	input  logic [7:0]           green,
	input  logic [7:0]           blue,
	output logic                 out_valid,
	output rthb_pkg::item_t      out_item
);
	import rthb_pkg::*;

	logic [7:0] mx;
	logic [7:0] mn;
	sector_t    sec;
	logic       neg;
	logic [7:0] mag;

	logic       valid_s1;
	side_t      side_s1;
	logic [7:0] mag_s1;

	logic [15:0] n_sat;
	logic [15:0] n_hue;

	always_comb begin
		mx = (red > green) ? red : green;
		mx = (mx > blue) ? mx : blue;
		mn = (red < green) ? red : green;
		mn = (mn < blue) ? mn : blue;
		// ties go to red, then green
		priority if (red == mx) begin
			sec = SEC_RED;
			neg = green < blue;
			mag = neg ? (blue - green) : (green - blue);
		end else if (green == mx) begin
			sec = SEC_GREEN;
			neg = blue < red;
			mag = neg ? (red - blue) : (blue - red);
		end else begin
			sec = SEC_BLUE;
			neg = red < green;
			mag = neg ? (green - red) : (red - green);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1.sector <= sec;
			side_s1.neg    <= neg;
			side_s1.maxv   <= mx;
			side_s1.delta  <= mx - mn;
			mag_s1         <= mag;
		end
	end

	// 255*delta and 43*|diff|, both below 256 times their divisor
	always_comb begin
		n_sat = {side_s1.delta, 8'd0} - {8'd0, side_s1.delta};
		n_hue = {8'd0, mag_s1} * {8'd0, HUE_SECTOR};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_item.side    <= side_s1;
			out_item.sat.rem <= n_sat[15:8];
			out_item.sat.low <= n_sat[7:0];
			out_item.hue.rem <= n_hue[15:8];
			out_item.hue.low <= n_hue[7:0];
		end
	end

endmodule

/* rtl/rthb_div_stage.sv */
// two restoring division steps for saturation and hue, one register stage
module rthb_div_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_valid,
	input  rthb_pkg::item_t      in_item,
	output logic                 out_valid,
	output rthb_pkg::item_t      out_item
);
	import rthb_pkg::*;

	div_t sat_a;
	div_t hue_a;
	div_t sat_b;
	div_t hue_b;

	always_comb begin
		sat_a = div_step(in_item.sat, in_item.side.maxv);
		sat_b = div_step(sat_a, in_item.side.maxv);
		hue_a = div_step(in_item.hue, in_item.side.delta);
		hue_b = div_step(hue_a, in_item.side.delta);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_item.side <= in_item.side;
			out_item.sat  <= sat_b;
			out_item.hue  <= hue_b;
		end
	end

endmodule

/* rtl/rthb_back.sv */
// hue offset and rounding fix-up, black and grey cases, output register
module rthb_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_valid,
	input  rthb_pkg::item_t      in_item,
	output logic                 out_valid,
	output logic [7:0]           hue,
	output logic [7:0]           saturation,
	output logic [7:0]           brightness
);
	import rthb_pkg::*;

	logic       black;
	logic       grey;
	logic [7:0] q;
	logic [7:0] q_up;
	logic [7:0] h;
	logic [7:0] s;

	always_comb begin
		black = (in_item.side.maxv == 8'd0);
		grey  = (in_item.side.delta == 8'd0);
		q     = in_item.hue.low;
		// floor of a negative quotient rounds away from zero when inexact
		q_up  = q + {7'd0, (in_item.hue.rem != 8'd0)};
		unique case (in_item.side.sector)
			SEC_RED:   h = in_item.side.neg ? (8'd0 - q) : q;
			SEC_GREEN: h = in_item.side.neg ? (HUE_GREEN - q_up) : (HUE_GREEN + q);
			SEC_BLUE:  h = in_item.side.neg ? (HUE_BLUE - q_up) : (HUE_BLUE + q);
			default:   h = 8'd0;
		endcase
		if (black || grey) begin
			h = 8'd0;
		end
		s = black ? 8'd0 : in_item.sat.low;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hue        <= h;
			saturation <= s;
			brightness <= in_item.side.maxv;
		end
	end

endmodule

/* rtl/rgb_to_hsv_byte.sv */
// top level of the 8-bit rgb to hsv pixel converter
//
// channel  dir  tdata bits (low first)                 tlast/tuser
// s_axis   in   red[7:0] green[15:8] blue[23:16]        none
// m_axis   out  hue[7:0] saturation[15:8] bright[23:16] none
//
// one pixel a cycle while the output is not stalled
// the two eight-step dividers run two steps per stage over four stages
// the whole pipe moves together when the output register is empty or being taken
// a stall freezes every stage, so no beat is lost or repeated
// reset clears only the stage valid bits
module rgb_to_hsv_byte (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // red, green, blue
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // hue, saturation, brightness
);
	import rthb_pkg::*;

	logic  adv;
	logic  valid_p [DIV_STAGES+1];
	item_t item_p  [DIV_STAGES+1];
	logic [7:0] hue;
	logic [7:0] saturation;
	logic [7:0] brightness;

	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	rthb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_axis_tvalid),
		.red       (s_axis_tdata[7:0]),
		.green     (s_axis_tdata[15:8]),
		.blue      (s_axis_tdata[23:16]),
		.out_valid (valid_p[0]),
		.out_item  (item_p[0])
	);

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		rthb_div_stage u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (valid_p[i]),
			.in_item   (item_p[i]),
			.out_valid (valid_p[i+1]),
			.out_item  (item_p[i+1])
		);
	end

	rthb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (valid_p[DIV_STAGES]),
		.in_item    (item_p[DIV_STAGES]),
		.out_valid  (m_axis_tvalid),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

	assign m_axis_tdata = {brightness, saturation, hue};

endmodule

/* rtl/rthb_check.sv */
// port-level checks for the rgb to hsv converter, bound to the top level
module rthb_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");

	// input side opens exactly when the output register can move
	a_ready_follow: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not track output stall");

	// black pixel gives all zeros
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[23:16] == 8'd0) |->
			(m_axis_tdata[15:0] == 16'd0))
		else $error("black pixel with non-zero hue or saturation");

	// zero saturation only for grey, which has zero hue
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[15:8] == 8'd0) |-> (m_axis_tdata[7:0] == 8'd0))
		else $error("grey pixel with non-zero hue");

endmodule

bind rgb_to_hsv_byte rthb_check u_check (.*);
